@@ src/enc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and class codes for the edge node classifier.
package enc_pkg;

	typedef logic [1:0] class_t;

	localparam class_t CLASS_DARK  = 2'd0;
	localparam class_t CLASS_LIGHT = 2'd1;
	localparam class_t CLASS_PAD   = 2'd2;

	localparam int OUT_CW = 10;   // width of write_row / write_col
	localparam int TYPE_W = 4;    // width of node_type
	localparam int BURST_N = 4;   // writes one pixel can cause

	typedef struct packed {
		logic [OUT_CW-1:0] row;
		logic [OUT_CW-1:0] col;
		logic [TYPE_W-1:0] node_type;
	} node_write_t;

	// all writes of one pixel: layer, which slots are live, slot payloads
	typedef struct packed {
		logic                          layer;
		logic [BURST_N-1:0]            mask;
		node_write_t [BURST_N-1:0]     wr;
	} node_burst_t;

endpackage

@@ src/edge_node_classifier_unit.sv @@
`timescale 1ns / 1ps
// Top level: pixel classing, line store, 3x3 window and edge node write generation.
//
//  channel | dir | tdata / payload                      | tuser | tlast
//  --------+-----+--------------------------------------+-------+-----------
//  s_*     | in  | [7:0] red_level                      | pad   | frame_end
//  m_*     | out | [0] layer, [10:1] row, [20:11] col,  |  -    | last_write
//          |     | [24:21] node_type, [31:25] zero      |       |
//  APB     | cfg | 0x0 grid_width, 0x4 dark_threshold   |  -    |  -
//
// A pixel request is taken every cycle as long as the line store stage can move on.
// Each pixel then causes 0 to 4 writes on the result port, one per cycle while
// m_tready is high, sent out by the write serializer.
// Path: accept -> line store read (registered) -> window and burst build -> output.
// Reset clears counters, window (all pad) and valid flags and loads config defaults; line store
// contents stay undefined and get no clearing pass. Stalls on m_tready back up
// through the burst register into s_tready; a pixel is never dropped.
module edge_node_classifier_unit #(
	parameter int MAX_GRID_WIDTH  = 1024,
	parameter int MAX_GRID_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// pixel stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // red_level
	input  logic        s_tuser,    // pad
	input  logic        s_tlast,    // frame_end
	// write stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // layer_index, write_row, write_col, node_type, zeros
	output logic        m_tlast,    // last_write
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW  = $clog2(MAX_GRID_WIDTH);
	localparam int RW  = $clog2(MAX_GRID_HEIGHT);
	localparam int RW1 = RW + 1;
	localparam int EW  = (CW + 1 > 11) ? CW + 1 : 11;

	typedef enum logic {REG_GRID_WIDTH, REG_DARK_THRESHOLD} reg_idx_t;

	// ---------------- configuration registers ----------------
	logic [10:0] grid_width_q;
	logic [7:0]  dark_thr_q;
	logic        cfg_wr;
	reg_idx_t    reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= 11'd1024;
			dark_thr_q   <= 8'd20;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GRID_WIDTH:     grid_width_q <= pwdata[10:0];
				REG_DARK_THRESHOLD: dark_thr_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GRID_WIDTH:     prdata = {21'd0, grid_width_q};
			REG_DARK_THRESHOLD: prdata = {24'd0, dark_thr_q};
			default:            prdata = '0;
		endcase
	end

	// ---------------- input side: class and position ----------------
	logic [EW-1:0]       gw_ext, eff_width;
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic                col_last, row_wrap;
	logic                s_acc;
	enc_pkg::class_t     cls_in;

	// clamp width to [3, MAX_GRID_WIDTH]
	always_comb begin
		gw_ext = EW'(grid_width_q);
		if (gw_ext < EW'(3))
			eff_width = EW'(3);
		else if (gw_ext > EW'(MAX_GRID_WIDTH))
			eff_width = EW'(MAX_GRID_WIDTH);
		else
			eff_width = gw_ext;
	end

	assign col_last = (EW'(col_q) + EW'(1)) >= eff_width;
	assign row_wrap = (RW1'(row_q) + RW1'(1)) >= RW1'(MAX_GRID_HEIGHT);

	// 255 - red is just the inverted byte
	assign cls_in = s_tuser ? enc_pkg::CLASS_PAD :
		((~s_tdata) < dark_thr_q) ? enc_pkg::CLASS_DARK : enc_pkg::CLASS_LIGHT;

	assign s_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_acc) begin
			if (s_tlast) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_last) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- stage 1: line store read-modify-write ----------------
	// word = {two rows up, one row up}
	logic [3:0]          line_mem [MAX_GRID_WIDTH];
	logic [3:0]          rd_s1;
	logic                valid_s1;
	enc_pkg::class_t     cur_s1;
	logic [CW-1:0]       c_s1;
	logic [RW-1:0]       r_s1;
	logic                fwd_s1;
	logic [3:0]          fwd_word_s1;
	enc_pkg::class_t     up1, up2;
	logic                s1_adv;
	logic                hit;
	logic                seq_ok;

	// the previous pixel writes back at the same edge this one reads; forward it
	assign up1 = fwd_s1 ? fwd_word_s1[1:0] : rd_s1[1:0];
	assign up2 = fwd_s1 ? fwd_word_s1[3:2] : rd_s1[3:2];

	assign s1_adv   = valid_s1 && (!hit || seq_ok);
	assign s_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk) begin
		if (s_acc) begin
			rd_s1 <= line_mem[col_q];
		end
		if (s1_adv) begin
			line_mem[c_s1] <= {up1, cur_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cur_s1      <= cls_in;
			c_s1        <= col_q;
			r_s1        <= row_q;
			fwd_s1      <= s1_adv && (c_s1 == col_q);
			fwd_word_s1 <= {up1, cur_s1};
		end
	end

	// ---------------- 3x3 window ----------------
	// row 0 = two rows up, row 2 = current row; column 2 is newest
	enc_pkg::class_t win_q [3][3];
	enc_pkg::class_t win_n [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_n[i][0] = win_q[i][1];
			win_n[i][1] = win_q[i][2];
		end
		win_n[0][2] = up2;
		win_n[1][2] = up1;
		win_n[2][2] = cur_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= enc_pkg::CLASS_PAD;
				end
			end
		end else if (s1_adv) begin
			win_q <= win_n;
		end
	end

	// ---------------- burst build ----------------
	enc_pkg::class_t      ctr;
	logic                 n1, n2, n3, n4, n5, n6, n7, n8;
	logic [RW-1:0]        r_m1;
	logic [CW-1:0]        c_m1;
	enc_pkg::node_burst_t burst;

	always_comb begin
		ctr  = win_n[1][1];
		n1   = (win_n[0][0] == ctr);
		n2   = (win_n[0][1] == ctr);
		n3   = (win_n[0][2] == ctr);
		n4   = (win_n[1][0] == ctr);
		n5   = (win_n[1][2] == ctr);
		n6   = (win_n[2][0] == ctr);
		n7   = (win_n[2][1] == ctr);
		n8   = (win_n[2][2] == ctr);
		r_m1 = r_s1 - RW'(1);
		c_m1 = c_s1 - CW'(1);
		hit  = (r_s1 >= RW'(2)) && (c_s1 >= CW'(2)) && (ctr != enc_pkg::CLASS_PAD);

		burst.layer = ctr[0];
		burst.mask  = {!n1, !n2, !n4, 1'b1};
		// own cell
		burst.wr[0] = {enc_pkg::OUT_CW'(r_s1), enc_pkg::OUT_CW'(c_s1), {n7, n8, n5, 1'b1}};
		// left
		burst.wr[1] = {enc_pkg::OUT_CW'(r_s1), enc_pkg::OUT_CW'(c_m1), {n6, n7, 1'b1, 1'b0}};
		// upper
		burst.wr[2] = {enc_pkg::OUT_CW'(r_m1), enc_pkg::OUT_CW'(c_s1), {1'b1, n5, n3, 1'b0}};
		// upper-left
		burst.wr[3] = {enc_pkg::OUT_CW'(r_m1), enc_pkg::OUT_CW'(c_m1), {n4, 1'b1, n2, 1'b0}};
	end

	// ---------------- write serializer ----------------
	enc_write_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s1_adv && hit),
		.burst    (burst),
		.load_ok  (seq_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// ---------------- assertions ----------------
	// a burst is only handed over when the serializer can take it
	a_burst_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && hit) |-> seq_ok)
		else $error("burst loaded while serializer busy");

	// a stuck stage 1 must hold off new pixels
	a_s1_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |-> !s_tready)
		else $error("pixel accepted over a stalled stage 1");

	// writes of one pixel leave back to back with no gap
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("gap inside a write burst");

endmodule

@@ src/enc_write_seq.sv @@
`timescale 1ns / 1ps
// Output stage: holds one pixel's write burst and sends it one write per cycle while m_tready is high.
module enc_write_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  enc_pkg::node_burst_t burst,
	output logic                load_ok,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,   // layer_index, write_row, write_col, node_type, zeros
	output logic                m_tlast    // last_write
);

	enc_pkg::node_burst_t              burst_q;
	logic [enc_pkg::BURST_N-1:0]       mask_q;
	logic [enc_pkg::BURST_N-1:0]       rest;
	logic [1:0]                        sel;
	enc_pkg::node_write_t              cur_wr;

	// lowest pending slot goes first (own, left, upper, upper-left)
	always_comb begin
		sel = 2'd0;
		for (int i = enc_pkg::BURST_N - 1; i >= 0; i--) begin
			if (mask_q[i]) sel = 2'(i);
		end
		rest     = mask_q & ~(enc_pkg::BURST_N'(1) << sel);
		cur_wr   = burst_q.wr[sel];
		m_tvalid = |mask_q;
		m_tlast  = (rest == '0);
		load_ok  = !m_tvalid || (m_tready && m_tlast);
		m_tdata  = {7'd0, cur_wr.node_type, cur_wr.col, cur_wr.row, burst_q.layer};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= burst.mask;
		end else if (m_tvalid && m_tready) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_q <= burst;
		end
	end

endmodule
